FILE: hw/rtl/pcs_pkg.sv
// Shared types for the pancake sorter: controller states, command and status bundles.
package pcs_pkg;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_SORT_INIT,
    ST_SORT_TOP,
    ST_SCAN,
    ST_SCAN_DRAIN,
    ST_DECIDE,
    ST_FLIP_CHK,
    ST_SWAP_WR_LO,
    ST_SWAP_WR_HI,
    ST_EMIT_RD,
    ST_EMIT_OUT
  } pcs_state_e;

  typedef struct packed {
    logic load_we;        // store input beat at fill count
    logic load_clr;       // clear fill count after emission
    logic unsorted_init;  // unsorted size := fill count
    logic unsorted_dec;   // prefix shrinks by one
    logic scan_start;     // scan pointer to zero
    logic scan_issue;     // read store at scan pointer, advance
    logic flip_init_a;    // flip range 0..largest
    logic flip_init_b;    // flip range 0..unsorted-1
    logic swap_rd;        // read both ends of flip range
    logic swap_wr_lo;     // write high value to low end
    logic swap_wr_hi;     // write low value to high end, narrow range
    logic emit_clr;       // emit index to zero
    logic emit_rd;        // read store at emit index
    logic emit_adv;       // next emit index
  } pcs_cmd_t;

  typedef struct packed {
    logic full;       // store holds MAX_ITEMS values
    logic single;     // unsorted prefix has at most one value
    logic scan_last;  // scan pointer is at end of prefix
    logic at_end;     // largest already at end of prefix
    logic flip_go;    // flip range still has a pair to swap
    logic emit_last;  // emit index is the final value
  } pcs_sts_t;

endpackage

FILE: hw/rtl/pcs_ctrl.sv
// Controller state machine for the pancake sorter.
module pcs_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_last_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  pcs_pkg::pcs_sts_t sts_i,
  output pcs_pkg::pcs_cmd_t cmd_o
);
  import pcs_pkg::*;

  pcs_state_e state_q, state_d;
  logic       second_q, second_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_LOAD;
      second_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      second_q <= second_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    second_d    = second_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      ST_LOAD: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_we = !sts_i.full;
          if (in_last_i) state_d = ST_SORT_INIT;
        end
      end
      ST_SORT_INIT: begin
        cmd_o.unsorted_init = 1'b1;
        state_d = ST_SORT_TOP;
      end
      ST_SORT_TOP: begin
        if (sts_i.single) begin
          cmd_o.emit_clr = 1'b1;
          state_d = ST_EMIT_RD;
        end else begin
          cmd_o.scan_start = 1'b1;
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.scan_issue = 1'b1;
        if (sts_i.scan_last) state_d = ST_SCAN_DRAIN;
      end
      ST_SCAN_DRAIN: begin
        state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (sts_i.at_end) begin
          cmd_o.unsorted_dec = 1'b1;
          state_d = ST_SORT_TOP;
        end else begin
          cmd_o.flip_init_a = 1'b1;
          second_d = 1'b0;
          state_d = ST_FLIP_CHK;
        end
      end
      ST_FLIP_CHK: begin
        if (sts_i.flip_go) begin
          cmd_o.swap_rd = 1'b1;
          state_d = ST_SWAP_WR_LO;
        end else if (!second_q) begin
          cmd_o.flip_init_b = 1'b1;
          second_d = 1'b1;
        end else begin
          cmd_o.unsorted_dec = 1'b1;
          state_d = ST_SORT_TOP;
        end
      end
      ST_SWAP_WR_LO: begin
        cmd_o.swap_wr_lo = 1'b1;
        state_d = ST_SWAP_WR_HI;
      end
      ST_SWAP_WR_HI: begin
        cmd_o.swap_wr_hi = 1'b1;
        state_d = ST_FLIP_CHK;
      end
      ST_EMIT_RD: begin
        cmd_o.emit_rd = 1'b1;
        state_d = ST_EMIT_OUT;
      end
      ST_EMIT_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (sts_i.emit_last) begin
            cmd_o.load_clr = 1'b1;
            state_d = ST_LOAD;
          end else begin
            cmd_o.emit_adv = 1'b1;
            state_d = ST_EMIT_RD;
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  // input and output sides are never open together
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input and output open in the same cycle");

endmodule

FILE: hw/rtl/pcs_dpath.sv
// Datapath for the pancake sorter: value store, pointers, max scan and swap registers.
module pcs_dpath #(
  parameter int MAX_ITEMS  = 64,
  parameter int VALUE_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  pcs_pkg::pcs_cmd_t     cmd_i,
  output pcs_pkg::pcs_sts_t     sts_o,
  input  logic [VALUE_BITS-1:0] in_value_i,
  output logic [VALUE_BITS-1:0] out_value_o
);
  import pcs_pkg::*;

  localparam int AW = $clog2(MAX_ITEMS);
  localparam int CW = $clog2(MAX_ITEMS + 1);

  logic [VALUE_BITS-1:0] mem_q [MAX_ITEMS];
  logic [VALUE_BITS-1:0] rd_a_q, rd_b_q;
  logic [VALUE_BITS-1:0] max_q;

  logic [CW-1:0] count_q, unsorted_q;
  logic [AW-1:0] scan_q, largest_q, lo_q, hi_q, emit_q, cmp_pos_q;
  logic          cmp_en_q, cmp_first_q;

  logic [CW-1:0] prefix_end;
  logic [AW-1:0] rd_a_addr;
  logic          rd_a_en;
  logic          take;

  assign prefix_end = unsorted_q - CW'(1);

  always_comb begin
    rd_a_en   = cmd_i.scan_issue | cmd_i.swap_rd | cmd_i.emit_rd;
    rd_a_addr = emit_q;
    if (cmd_i.scan_issue) rd_a_addr = scan_q;
    else if (cmd_i.swap_rd) rd_a_addr = lo_q;
  end

  // store: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_we) mem_q[count_q[AW-1:0]] <= in_value_i;
    else if (cmd_i.swap_wr_lo) mem_q[lo_q] <= rd_b_q;
    else if (cmd_i.swap_wr_hi) mem_q[hi_q] <= rd_a_q;
  end

  always_ff @(posedge clk_i) begin
    if (rd_a_en) rd_a_q <= mem_q[rd_a_addr];
    if (cmd_i.swap_rd) rd_b_q <= mem_q[hi_q];
  end

  // first value of a scan always loads; later ones only when strictly greater
  assign take = cmp_en_q && (cmp_first_q || ($signed(rd_a_q) > $signed(max_q)));

  always_ff @(posedge clk_i) begin
    if (take) max_q <= rd_a_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      unsorted_q  <= '0;
      scan_q      <= '0;
      largest_q   <= '0;
      lo_q        <= '0;
      hi_q        <= '0;
      emit_q      <= '0;
      cmp_pos_q   <= '0;
      cmp_en_q    <= 1'b0;
      cmp_first_q <= 1'b0;
    end else begin
      cmp_en_q <= cmd_i.scan_issue;
      if (cmd_i.load_we) count_q <= count_q + CW'(1);
      else if (cmd_i.load_clr) count_q <= '0;
      if (cmd_i.unsorted_init) unsorted_q <= count_q;
      else if (cmd_i.unsorted_dec) unsorted_q <= unsorted_q - CW'(1);
      if (cmd_i.scan_start) scan_q <= '0;
      else if (cmd_i.scan_issue) begin
        scan_q      <= scan_q + AW'(1);
        cmp_pos_q   <= scan_q;
        cmp_first_q <= (scan_q == '0);
      end
      if (take) largest_q <= cmp_pos_q;
      if (cmd_i.flip_init_a) begin
        lo_q <= '0;
        hi_q <= largest_q;
      end else if (cmd_i.flip_init_b) begin
        lo_q <= '0;
        hi_q <= prefix_end[AW-1:0];
      end else if (cmd_i.swap_wr_hi) begin
        lo_q <= lo_q + AW'(1);
        hi_q <= hi_q - AW'(1);
      end
      if (cmd_i.emit_clr) emit_q <= '0;
      else if (cmd_i.emit_adv) emit_q <= emit_q + AW'(1);
    end
  end

  always_comb begin
    sts_o           = '0;
    sts_o.full      = (count_q == CW'(MAX_ITEMS));
    sts_o.single    = (unsorted_q <= CW'(1));
    sts_o.scan_last = (CW'(scan_q) == prefix_end);
    sts_o.at_end    = (CW'(largest_q) == prefix_end);
    sts_o.flip_go   = (lo_q < hi_q);
    sts_o.emit_last = (CW'(emit_q) == count_q - CW'(1));
  end

  assign out_value_o = rd_a_q;

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_we |-> (count_q < CW'(MAX_ITEMS)))
    else $error("store written beyond capacity");

  a_swap_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.swap_rd |=> (lo_q < hi_q) && cmd_i.swap_wr_lo)
    else $error("swap started on an empty flip range");

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.scan_issue |-> (CW'(scan_q) < unsorted_q) && (unsorted_q <= count_q))
    else $error("scan beyond the unsorted prefix");

endmodule

FILE: hw/rtl/pancake_sorter_unit.sv
// Top level of the pancake sorter: stream ports, controller and datapath.
//
// Usage: values arrive on the s_axis channel, one signed value per beat; tlast marks the
// final value of a set. Up to MAX_ITEMS values are kept; beats beyond that are dropped,
// but a dropped beat with tlast still closes the set. After the last beat the block sorts
// the set in place by pancake sort and then sends it, ascending, on the m_axis channel,
// with tlast on the largest (final) value. The input stays closed from the last beat of
// a set until the final output beat has been taken.
// Operation: loading accepts one beat per cycle. Sorting an n-value set runs, for each
// prefix size u from n down to 2, a scan of the u values through one store read port,
// plus, when the largest value is out of place, flip setup and the two flips, each pair
// swapped by a read of both ends, then a write to the low end and one to the high end.
// Emission handles each beat as a store read, then presentation, and the next store
// read waits until the beat has been taken. When the receiver
// stalls, m_axis_tdata and m_axis_tlast hold until taken. Reset returns the block to
// loading with an empty store; no clearing pass is needed.
module pancake_sorter_unit #(
  parameter int MAX_ITEMS  = 64,
  parameter int VALUE_BITS = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [((VALUE_BITS+7)/8)*8-1:0]     s_axis_tdata,  // value
  input  logic                                s_axis_tlast,  // is_last
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [((VALUE_BITS+7)/8)*8-1:0]     m_axis_tdata,  // sorted_value
  output logic                                m_axis_tlast   // end_of_set
);
  import pcs_pkg::*;

  localparam int DW = ((VALUE_BITS + 7) / 8) * 8;

  pcs_cmd_t              cmd;
  pcs_sts_t              sts;
  logic [VALUE_BITS-1:0] out_value;

  pcs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_last_i   (s_axis_tlast),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  pcs_dpath #(
    .MAX_ITEMS  (MAX_ITEMS),
    .VALUE_BITS (VALUE_BITS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_value_i  (s_axis_tdata[VALUE_BITS-1:0]),
    .out_value_o (out_value)
  );

  assign m_axis_tdata = DW'(out_value);
  assign m_axis_tlast = sts.emit_last;

endmodule

FILE: sim/testbench.sv
// Self-checking testbench for pancake_sorter_unit: random sets in, sorted sets checked out.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_ITEMS   = 64;
  localparam int VALUE_BITS  = 32;
  localparam int DATA_BITS   = ((VALUE_BITS + 7) / 8) * 8;
  localparam int SMALL_ITEMS = 300;
  localparam int SETTLE      = 200;
  localparam int HOLD_CYCLES = 400;
  localparam int unsigned CYCLE_LIMIT = 1000000;

  typedef logic signed [VALUE_BITS-1:0] value_t;

  typedef struct {
    value_t value;
    logic   last;
  } sorted_beat_t;

  class sorted_set_tracker;
    value_t       held[MAX_ITEMS];
    int           fill;
    sorted_beat_t sorted_due[$];
    int           errors;

    function new();
      fill   = 0;
      errors = 0;
    endfunction

    task report_mismatch(string msg);
      errors++;
      $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    function void flip_front(int hi);
      int     lo;
      value_t t;
      lo = 0;
      while (lo < hi) begin
        t        = held[lo];
        held[lo] = held[hi];
        held[hi] = t;
        lo++;
        hi--;
      end
    endfunction

    function void pancake_sort_held();
      int unsorted;
      int top;
      unsorted = fill;
      while (unsorted > 1) begin
        top = 0;
        // first largest wins on ties
        for (int k = 1; k < unsorted; k++) begin
          if (held[k] > held[top]) top = k;
        end
        if (top != unsorted - 1) begin
          flip_front(top);
          flip_front(unsorted - 1);
        end
        unsorted--;
      end
    endfunction

    function void note_input(value_t v, logic last);
      sorted_beat_t b;
      if (fill < MAX_ITEMS) begin
        held[fill] = v;
        fill++;
      end
      if (last) begin
        pancake_sort_held();
        for (int k = 0; k < fill; k++) begin
          b.value = held[k];
          b.last  = (k == fill - 1);
          sorted_due.push_back(b);
        end
        fill = 0;
      end
    endfunction

    task check_result(value_t v, logic last);
      sorted_beat_t b;
      if (sorted_due.size() == 0) begin
        report_mismatch($sformatf("unexpected beat value %0d last %0b", v, last));
      end else begin
        b = sorted_due.pop_front();
        if (v !== b.value)
          report_mismatch($sformatf("sorted_value got %0d want %0d", v, b.value));
        if (last !== b.last)
          report_mismatch($sformatf("end_of_set got %0b want %0b (value %0d)",
                                    last, b.last, b.value));
      end
    endtask

    function int pending();
      return sorted_due.size();
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [DATA_BITS-1:0] s_axis_tdata = '0;
  logic                 s_axis_tlast = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [DATA_BITS-1:0] m_axis_tdata;
  logic                 m_axis_tlast;

  sorted_set_tracker board = new();

  int          tx_idle_pct = 24;
  int          rx_idle_pct = 83;
  int          hold_req = 0;
  int unsigned cycle_count = 0;
  value_t      set_buf[$];

  pancake_sorter_unit #(
    .MAX_ITEMS (MAX_ITEMS),
    .VALUE_BITS(VALUE_BITS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("testbench failed");
    $finish;
  end

  // beat monitors
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready)
      board.note_input(value_t'(s_axis_tdata[VALUE_BITS-1:0]), s_axis_tlast);
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      board.check_result(value_t'(m_axis_tdata[VALUE_BITS-1:0]), m_axis_tlast);
  end

  // receiver: random stalls, or a long hold-off when asked
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req != 0) begin
        m_axis_tready <= 1'b0;
        repeat (hold_req) @(posedge clk_i);
        hold_req = 0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  task send_beat(input value_t v, input logic last);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= DATA_BITS'(v);
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task send_set_buf();
    for (int k = 0; k < set_buf.size(); k++) send_beat(set_buf[k], k == set_buf.size() - 1);
  endtask

  function value_t pick_value();
    case ($urandom_range(3))
      0: return value_t'($urandom_range(8)) - 4;  // narrow range, lots of ties
      1: begin
        case ($urandom_range(3))
          0: return {1'b1, {(VALUE_BITS-1){1'b0}}};
          1: return {1'b0, {(VALUE_BITS-1){1'b1}}};
          2: return '0;
          default: return '1;
        endcase
      end
      default: return value_t'($urandom);
    endcase
  endfunction

  task build_set(input int n);
    set_buf.delete();
    for (int k = 0; k < n; k++) set_buf.push_back(pick_value());
  endtask

  // stop offering the last beat again, then wait for every sorted beat
  task wait_drained();
    s_axis_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
  endtask

  initial begin
    int small_sent;
    int set_idx;
    int n;
    bit hold_done;

    small_sent = 0;
    set_idx    = 0;
    hold_done  = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // single value, then extremes, ties, sorted and reversed sets
    set_buf = '{32'sh7fffffff};
    send_set_buf();
    set_buf = '{32'sh7fffffff, 32'sh80000000, 32'sh00000000, 32'shffffffff};
    send_set_buf();
    set_buf = '{32'sd5, 32'sd5, -32'sd3, 32'sd5, 32'sd5};
    send_set_buf();
    set_buf = '{-32'sd7, -32'sd1, 32'sd2, 32'sd9};
    send_set_buf();
    set_buf = '{32'sd9, 32'sd2, -32'sd1, -32'sd7};
    send_set_buf();

    // sender holds back until every sorted beat is out
    wait_drained();

    while (small_sent < SMALL_ITEMS) begin
      if (small_sent >= 2 * SMALL_ITEMS / 3) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end else if (small_sent >= SMALL_ITEMS / 3) begin
        tx_idle_pct = 83;
        rx_idle_pct = 24;
      end
      if (set_idx == 2) begin
        build_set(MAX_ITEMS);
      end else if (set_idx == 5) begin
        // overflow: extra beats dropped, last one still closes the set
        build_set(MAX_ITEMS + $urandom_range(3, 1));
      end else begin
        n = ($urandom_range(9) == 0) ? $urandom_range(32, 13) : $urandom_range(12, 1);
        build_set(n);
      end
      small_sent += set_buf.size();
      send_set_buf();
      set_idx++;
      if (!hold_done && small_sent >= 40 && set_buf.size() < 16) begin
        // next set keeps offering while the output is held off
        hold_req  = HOLD_CYCLES;
        hold_done = 1;
      end
    end
    s_axis_tlast  <= 1'b0;

    wait_drained();
    repeat (SETTLE) @(posedge clk_i);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/pcs_pkg.sv
hw/rtl/pcs_ctrl.sv
hw/rtl/pcs_dpath.sv
hw/rtl/pancake_sorter_unit.sv
sim/testbench.sv
